[src/gbe_pkg.sv]
// Package for the gap buffer editor: field widths, action and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package gbe_pkg;

	localparam int DEF_CAPACITY = 256;

	localparam int ACT_W  = 3;
	localparam int CHAR_W = 8;
	localparam int CNT_W  = 9;
	localparam int IDX_W  = 8;
	localparam int ST_W   = 2;

	localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_LEFT       = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RIGHT      = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DEL_BEFORE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DEL_AFTER  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_READ       = 3'd5;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_CLAMPED = 2'd2;
	localparam logic [ST_W-1:0] ST_BEYOND  = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // latch the beat, clamp the count, issue a text read for a read action
		logic exec;     // apply insert / delete
		logic step;     // one copy step of a cursor move
		logic finish;   // load the result registers, raise done
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_move;
		logic move_busy;
	} stat_t;

endpackage

[src/gap_buffer_editor_top.sv]
// Top level of the gap buffer editor: controller and datapath.
// Depends on gbe_pkg, gbe_ctrl, gbe_dp.
//
// Channel   Handshake            Payload
// -------   ------------------   ----------------------------------------
// action    start & !busy         action, char_in, count, read_index
// result    done (one cycle)      char_out, cursor, text_length, status
//
// Sequencing: insert, delete, read and unused actions pass from accept through
// the execute state to the done beat; a cursor move of n characters (after
// clamping, n > 0) also runs the copy loop, one character per cycle through the
// store's registered read port and single write port.
// Reset: arst_n clears the controller and the gap pointers (empty text,
// cursor 0); the text store itself is not cleared and needs no sweep.
// Stalls: done is a one-cycle strobe the receiver cannot hold off; results
// sit in registers, so the next beat may be taken in the cycle done is high.
module gap_buffer_editor_top #(
	parameter int CAPACITY = gbe_pkg::DEF_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [gbe_pkg::ACT_W-1:0]   action,
	input  logic [gbe_pkg::CHAR_W-1:0]  char_in,
	input  logic [gbe_pkg::CNT_W-1:0]   count,
	input  logic [gbe_pkg::IDX_W-1:0]   read_index,
	output logic                        done,
	output logic [gbe_pkg::CHAR_W-1:0]  char_out,
	output logic [gbe_pkg::CNT_W-1:0]   cursor,
	output logic [gbe_pkg::CNT_W-1:0]   text_length,
	output logic [gbe_pkg::ST_W-1:0]    status
);
	import gbe_pkg::*;

	// command and status between the two halves
	cmd_t  cmd;
	stat_t st;

	// controller: idle / execute / copy loop
	gbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: pointers, text store, clamp and result registers
	gbe_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.action      (action),
		.char_in     (char_in),
		.count       (count),
		.read_index  (read_index),
		.done        (done),
		.char_out    (char_out),
		.cursor      (cursor),
		.text_length (text_length),
		.status      (status)
	);

endmodule

[src/gbe_ctrl.sv]
// Controller state machine of the gap buffer editor.
// Depends on gbe_pkg.
module gbe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gbe_pkg::stat_t  st,
	output gbe_pkg::cmd_t   cmd,
	output logic            busy
);
	import gbe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_MOVE = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = start;
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.is_move) begin
					cmd.step = 1'b1;
					if (st.move_busy) begin
						state_d = S_MOVE;
					end else begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.exec   = 1'b1;
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_MOVE: begin
				cmd.step = 1'b1;
				if (!st.move_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

[src/gbe_dp.sv]
// Datapath of the gap buffer editor: gap pointers, text store, clamp logic,
// copy pipeline and result registers. Depends on gbe_pkg.
module gbe_dp #(
	parameter int CAPACITY = gbe_pkg::DEF_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gbe_pkg::cmd_t               cmd,
	output gbe_pkg::stat_t              st,
	input  logic [gbe_pkg::ACT_W-1:0]   action,
	input  logic [gbe_pkg::CHAR_W-1:0]  char_in,
	input  logic [gbe_pkg::CNT_W-1:0]   count,
	input  logic [gbe_pkg::IDX_W-1:0]   read_index,
	output logic                        done,
	output logic [gbe_pkg::CHAR_W-1:0]  char_out,
	output logic [gbe_pkg::CNT_W-1:0]   cursor,
	output logic [gbe_pkg::CNT_W-1:0]   text_length,
	output logic [gbe_pkg::ST_W-1:0]    status
);
	import gbe_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = (PW > CNT_W) ? PW : CNT_W;
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

	// architectural state
	logic [PW-1:0] gap_q, after_q;
	logic [PW-1:0] gap_d, after_d;

	// latched beat
	logic [ACT_W-1:0]  action_q;
	logic [CHAR_W-1:0] char_q;
	logic [CNT_W-1:0]  rem_q;
	logic [ST_W-1:0]   status_q;
	logic [PW-1:0]     rp_q;
	logic              pend_q;

	// store
	logic [CHAR_W-1:0] mem [CAPACITY];
	logic [CHAR_W-1:0] rdata_q;
	logic              wen, ren;
	logic [AW-1:0]     waddr, raddr, raddr_rd;
	logic [CHAR_W-1:0] wdata;

	// accept-time arithmetic
	logic [CW-1:0]    gap_w, after_w, avail_r, len_w, cnt_w, ridx_w;
	logic             clamp_l, clamp_r;
	logic [CNT_W-1:0] n_l, n_r, n_acc;
	logic [ST_W-1:0]  st_acc;
	logic             issue, act_left;

	// result registers
	logic              done_q;
	logic [CHAR_W-1:0] char_out_q;
	logic [CNT_W-1:0]  cursor_q, length_q;
	logic [ST_W-1:0]   status_out_q;

	always_comb begin
		gap_w   = CW'(gap_q);
		after_w = CW'(after_q);
		avail_r = CW'(CAP_P - after_q);
		len_w   = CW'(gap_q + CAP_P - after_q);
		cnt_w   = CW'(count);
		ridx_w  = CW'(read_index);
		clamp_l = (cnt_w > gap_w);
		clamp_r = (cnt_w > avail_r);
		n_l     = clamp_l ? CNT_W'(gap_w) : count;
		n_r     = clamp_r ? CNT_W'(avail_r) : count;
		raddr_rd = (ridx_w < gap_w) ? AW'(ridx_w) : AW'(after_w + ridx_w - gap_w);
		n_acc   = '0;
		st_acc  = ST_OK;
		unique case (action)
			ACT_INSERT: begin
				st_acc = (gap_q >= after_q) ? ST_FULL : ST_OK;
			end
			ACT_LEFT, ACT_DEL_BEFORE: begin
				n_acc  = n_l;
				st_acc = clamp_l ? ST_CLAMPED : ST_OK;
			end
			ACT_RIGHT, ACT_DEL_AFTER: begin
				n_acc  = n_r;
				st_acc = clamp_r ? ST_CLAMPED : ST_OK;
			end
			ACT_READ: begin
				st_acc = (ridx_w >= len_w) ? ST_BEYOND : ST_OK;
			end
			default: begin
				st_acc = ST_OK;
			end
		endcase
	end

	assign act_left     = (action_q == ACT_LEFT);
	assign issue        = cmd.step && (rem_q != '0);
	assign st.is_move   = act_left || (action_q == ACT_RIGHT);
	assign st.move_busy = (rem_q != '0) || pend_q;

	// next pointers and the single write port
	always_comb begin
		gap_d   = gap_q;
		after_d = after_q;
		wen     = 1'b0;
		waddr   = gap_q[AW-1:0];
		wdata   = char_q;
		if (cmd.exec) begin
			unique case (action_q)
				ACT_INSERT: begin
					if (status_q != ST_FULL) begin
						wen   = 1'b1;
						gap_d = gap_q + 1'b1;
					end
				end
				ACT_DEL_BEFORE: gap_d   = gap_q - PW'(rem_q);
				ACT_DEL_AFTER:  after_d = after_q + PW'(rem_q);
				default: begin
					gap_d = gap_q;
				end
			endcase
		end
		if (cmd.step && pend_q) begin
			wen   = 1'b1;
			wdata = rdata_q;
			if (act_left) begin
				waddr   = AW'(after_q - 1'b1);
				gap_d   = gap_q - 1'b1;
				after_d = after_q - 1'b1;
			end else begin
				waddr   = gap_q[AW-1:0];
				gap_d   = gap_q + 1'b1;
				after_d = after_q + 1'b1;
			end
		end
	end

	assign raddr = cmd.accept ? raddr_rd : rp_q[AW-1:0];
	assign ren   = (cmd.accept && (action == ACT_READ)) || issue;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q   <= '0;
			after_q <= CAP_P;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			gap_q   <= gap_d;
			after_q <= after_d;
			pend_q  <= issue;
			done_q  <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= action;
			char_q   <= char_in;
			rem_q    <= n_acc;
			status_q <= st_acc;
			rp_q     <= (action == ACT_LEFT) ? gap_q - 1'b1 : after_q;
		end else if (issue) begin
			rem_q <= rem_q - 1'b1;
			rp_q  <= act_left ? rp_q - 1'b1 : rp_q + 1'b1;
		end
		if (cmd.finish) begin
			char_out_q   <= ((action_q == ACT_READ) && (status_q == ST_OK)) ? rdata_q : '0;
			cursor_q     <= CNT_W'(gap_d);
			length_q     <= CNT_W'(gap_d + CAP_P - after_d);
			status_out_q <= status_q;
		end
	end

	assign done        = done_q;
	assign char_out    = char_out_q;
	assign cursor      = cursor_q;
	assign text_length = length_q;
	assign status      = status_out_q;

endmodule

[tb/gap_buffer_editor_checker.sv]
`timescale 1ns / 1ps
// Checker for the gap buffer editor: tracks its own copy of the text and gap,
// predicts each result beat and compares it with the block. Depends on gbe_pkg.
module gap_buffer_editor_checker #(
	parameter int CAPACITY = gbe_pkg::DEF_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [gbe_pkg::ACT_W-1:0]   action,
	input  logic [gbe_pkg::CHAR_W-1:0]  char_in,
	input  logic [gbe_pkg::CNT_W-1:0]   count,
	input  logic [gbe_pkg::IDX_W-1:0]   read_index,
	input  logic                        done,
	input  logic [gbe_pkg::CHAR_W-1:0]  char_out,
	input  logic [gbe_pkg::CNT_W-1:0]   cursor,
	input  logic [gbe_pkg::CNT_W-1:0]   text_length,
	input  logic [gbe_pkg::ST_W-1:0]    status,
	output int                          mismatch_count,
	output int                          results_due
);
	import gbe_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic [CNT_W-1:0]  cursor;
		logic [CNT_W-1:0]  text_length;
		logic [ST_W-1:0]   status;
	} edit_result_t;

	logic [CHAR_W-1:0] text_copy [CAPACITY];
	int                gap_lo;   // first free slot, i.e. the cursor
	int                gap_hi;   // first slot of the text after the cursor
	edit_result_t      due_results [$];

	function automatic edit_result_t apply_edit(input logic [ACT_W-1:0] act,
		input logic [CHAR_W-1:0] ch, input int cnt, input int idx);
		edit_result_t r;
		int           n;
		int           avail;
		int           len;
		r = '0;
		r.status = ST_OK;
		avail = (act == ACT_LEFT || act == ACT_DEL_BEFORE) ? gap_lo : CAPACITY - gap_hi;
		n = cnt;
		if ((act == ACT_LEFT || act == ACT_RIGHT || act == ACT_DEL_BEFORE ||
				act == ACT_DEL_AFTER) && n > avail) begin
			n = avail;
			r.status = ST_CLAMPED;
		end
		case (act)
			ACT_INSERT: begin
				if (gap_lo >= gap_hi) begin
					r.status = ST_FULL;
				end else begin
					text_copy[gap_lo] = ch;
					gap_lo++;
				end
			end
			ACT_LEFT: begin
				for (int k = 0; k < n; k++) begin
					gap_lo--;
					gap_hi--;
					text_copy[gap_hi] = text_copy[gap_lo];
				end
			end
			ACT_RIGHT: begin
				for (int k = 0; k < n; k++) begin
					text_copy[gap_lo] = text_copy[gap_hi];
					gap_lo++;
					gap_hi++;
				end
			end
			ACT_DEL_BEFORE: gap_lo -= n;
			ACT_DEL_AFTER:  gap_hi += n;
			ACT_READ: begin
				len = gap_lo + CAPACITY - gap_hi;
				if (idx >= len)
					r.status = ST_BEYOND;
				else if (idx < gap_lo)
					r.char_out = text_copy[idx];
				else
					r.char_out = text_copy[gap_hi + idx - gap_lo];
			end
			default: ;
		endcase
		r.cursor = CNT_W'(gap_lo);
		r.text_length = CNT_W'(gap_lo + CAPACITY - gap_hi);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		edit_result_t want;
		if (!arst_n) begin
			due_results.delete();
			gap_lo = 0;
			gap_hi = CAPACITY;
			for (int i = 0; i < CAPACITY; i++)
				text_copy[i] = '0;
			mismatch_count = 0;
			results_due = 0;
		end else begin
			// a result beat and the next command beat may share an edge;
			// the result always belongs to an older command
			if (done) begin
				if (due_results.size() == 0) begin
					$error("result beat with no command outstanding");
					mismatch_count++;
				end else begin
					want = due_results.pop_front();
					if (char_out !== want.char_out) begin
						$error("char_out: expected %0d, got %0d", want.char_out, char_out);
						mismatch_count++;
					end
					if (cursor !== want.cursor) begin
						$error("cursor: expected %0d, got %0d", want.cursor, cursor);
						mismatch_count++;
					end
					if (text_length !== want.text_length) begin
						$error("text_length: expected %0d, got %0d",
							want.text_length, text_length);
						mismatch_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				due_results.push_back(apply_edit(action, char_in, int'(count),
					int'(read_index)));
			results_due = due_results.size();
		end
	end

endmodule

[tb/gap_buffer_editor_top_test.sv]
`timescale 1ns / 1ps
// Test top for the gap buffer editor: clock, reset and command stimulus.
// Depends on gbe_pkg, gap_buffer_editor_top and gap_buffer_editor_checker.
module gap_buffer_editor_top_test;
	import gbe_pkg::*;

	// action codes the block does not use; they must leave the text alone
	localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

	// longest legal quiet spell is a 256-character move plus the longest random idle gap
	localparam int WATCHDOG_LIMIT = 2000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [ACT_W-1:0]  action;
	logic [CHAR_W-1:0] char_in;
	logic [CNT_W-1:0]  count;
	logic [IDX_W-1:0]  read_index;
	logic              done;
	logic [CHAR_W-1:0] char_out;
	logic [CNT_W-1:0]  cursor;
	logic [CNT_W-1:0]  text_length;
	logic [ST_W-1:0]   status;

	int mismatch_count;
	int results_due;
	int stall_cycles;
	bit no_gaps;   // set for bursts of back-to-back command beats

	initial clk = 1'b0;
	always #5 clk = ~clk;

	gap_buffer_editor_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.char_in     (char_in),
		.count       (count),
		.read_index  (read_index),
		.done        (done),
		.char_out    (char_out),
		.cursor      (cursor),
		.text_length (text_length),
		.status      (status)
	);

	gap_buffer_editor_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.char_in        (char_in),
		.count          (count),
		.read_index     (read_index),
		.done           (done),
		.char_out       (char_out),
		.cursor         (cursor),
		.text_length    (text_length),
		.status         (status),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	// Watchdog: any command or result beat counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Present one command beat and hold it until taken. Called at a falling
	// edge, returns at the falling edge after acceptance with start still high,
	// so a back-to-back beat never drops start in between.
	task automatic issue(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
		input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] idx);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      <= 1'b1;
		action     <= act;
		char_in    <= ch;
		count      <= cnt;
		read_index <= idx;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Hold off new commands until every predicted result has come back.
	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (results_due != 0);
	endtask

	// Mostly short counts, now and then anything up to the whole buffer.
	function automatic logic [CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 5)
			return CNT_W'($urandom_range(0, 4));
		else if (r <= 7)
			return CNT_W'($urandom_range(0, 32));
		else if (r == 8)
			return CNT_W'($urandom_range(0, DEF_CAPACITY));
		return CNT_W'(DEF_CAPACITY);
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		return $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 15))
			: IDX_W'($urandom_range(0, 255));
	endfunction

	// Weighted mix of every action; idle gaps between beats switch on and off as it runs.
	task automatic run_mix(input int beats);
		int               pick;
		logic [ACT_W-1:0] act;
		for (int b = 0; b < beats; b++) begin
			if (b % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 30)
				act = ACT_INSERT;
			else if (pick < 45)
				act = ACT_LEFT;
			else if (pick < 60)
				act = ACT_RIGHT;
			else if (pick < 70)
				act = ACT_DEL_BEFORE;
			else if (pick < 80)
				act = ACT_DEL_AFTER;
			else if (pick < 98)
				act = ACT_READ;
			else if (pick == 98)
				act = ACT_SPARE_6;
			else
				act = ACT_SPARE_7;
			issue(act, CHAR_W'($urandom_range(0, 255)), pick_count(), pick_index());
		end
	endtask

	initial begin
		int               inserts;
		logic [ACT_W-1:0] side_act;
		arst_n     = 1'b0;
		start      = 1'b0;
		action     = ACT_INSERT;
		char_in    = '0;
		count      = '0;
		read_index = '0;
		no_gaps    = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty text edge cases first, then a short text worked over.
		issue(ACT_READ,       8'h00, 9'd0,   8'd0);    // read of empty text
		issue(ACT_LEFT,       8'h00, 9'd0,   8'd0);    // zero count fits
		issue(ACT_LEFT,       8'hFF, 9'd5,   8'hFF);   // nothing to the left
		issue(ACT_RIGHT,      8'h00, 9'd256, 8'd0);
		issue(ACT_DEL_BEFORE, 8'h00, 9'd1,   8'd0);
		issue(ACT_DEL_AFTER,  8'h00, 9'd256, 8'd0);
		issue(ACT_INSERT,     8'h00, 9'd0,   8'd0);
		issue(ACT_INSERT,     8'hFF, 9'h1FF, 8'hFF);
		issue(ACT_INSERT,     8'hA5, 9'd0,   8'd0);
		issue(ACT_INSERT,     8'h5A, 9'd0,   8'd0);
		issue(ACT_LEFT,       8'h00, 9'd2,   8'd0);
		issue(ACT_READ,       8'h00, 9'd0,   8'd0);
		issue(ACT_READ,       8'h00, 9'd3,   8'd0);
		issue(ACT_READ,       8'h00, 9'd0,   8'd255);  // far past the end
		issue(ACT_RIGHT,      8'h00, 9'd256, 8'd0);    // only two to the right
		issue(ACT_LEFT,       8'h00, 9'd256, 8'd0);
		issue(ACT_DEL_AFTER,  8'h00, 9'd1,   8'd0);
		issue(ACT_RIGHT,      8'h00, 9'd0,   8'd0);
		issue(ACT_DEL_BEFORE, 8'h00, 9'd0,   8'd0);
		issue(ACT_SPARE_6,    8'hFF, 9'd256, 8'd1);
		issue(ACT_SPARE_7,    8'h80, 9'd3,   8'd2);
		issue(ACT_READ,       8'h00, 9'd0,   8'd2);
		issue(ACT_DEL_AFTER,  8'h00, 9'd256, 8'd0);
		issue(ACT_INSERT,     8'h80, 9'd0,   8'd0);
		issue(ACT_READ,       8'h00, 9'd0,   8'd0);

		run_mix(200);
		drain_results();

		// Wipe the text, then fill it past capacity so inserts get refused
		// and cursor and length reach the top of their range.
		issue(ACT_DEL_BEFORE, 8'h00, 9'd256, 8'd0);
		issue(ACT_DEL_AFTER,  8'h00, 9'd256, 8'd0);
		inserts = 0;
		while (inserts < DEF_CAPACITY + 10) begin
			if (inserts % 40 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 3))
					0:       side_act = ACT_LEFT;
					1:       side_act = ACT_RIGHT;
					2:       side_act = ACT_READ;
					default: side_act = ACT_SPARE_6;
				endcase
				issue(side_act, CHAR_W'($urandom_range(0, 255)), pick_count(),
					IDX_W'($urandom_range(0, 255)));
			end else begin
				issue(ACT_INSERT, CHAR_W'($urandom_range(0, 255)), pick_count(),
					pick_index());
				inserts++;
			end
		end

		run_mix(200);
		drain_results();
		run_mix(300);

		drain_results();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
